@@ design/qau_pkg.sv @@
`default_nettype none
package qau_pkg;

  localparam int unsigned FX_W     = 32;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned PROD_W   = 2 * FX_W;
  localparam int unsigned SUM_W    = PROD_W + 2;
  localparam int unsigned MR_LAT   = 6;
  localparam int unsigned M_W      = 29;
  localparam int unsigned RAD_W    = 2 * M_W + 2;
  localparam int unsigned ROOT_W   = RAD_W / 2;
  localparam int unsigned Q_W      = FRAC_W + 1;
  localparam int unsigned NUM_W    = M_W + FRAC_W + 1;
  localparam int unsigned NORM_LAT = 4 + ROOT_W + 1 + Q_W + 1;
  localparam int unsigned DEPTH    = NORM_LAT + 1;

  localparam logic [1:0] ACT_MUL  = 2'd0;
  localparam logic [1:0] ACT_ROT  = 2'd1;
  localparam logic [1:0] ACT_NORM = 2'd2;

  typedef logic signed [FX_W-1:0]   fx_t;
  typedef fx_t                      quat_t [4];
  typedef logic signed [PROD_W-1:0] prod_t;
  typedef logic signed [SUM_W-1:0]  sum_t;

  typedef struct packed {
    logic sat;
    fx_t  x;
    fx_t  y;
    fx_t  z;
    fx_t  w;
  } res_t;

  // round half up to Q16.16, then clamp; msb of the result is the clamp flag
  function automatic logic [FX_W:0] rnd_clamp(input sum_t s);
    sum_t                        t;
    logic [SUM_W-FRAC_W-1:0]     q;
    t = s + (sum_t'(1) <<< (FRAC_W - 1));
    q = t[SUM_W-1:FRAC_W];
    if (q[SUM_W-FRAC_W-1:FX_W-1] == {(SUM_W-FRAC_W-FX_W+1){q[SUM_W-FRAC_W-1]}}) begin
      rnd_clamp = {1'b0, q[FX_W-1:0]};
    end else begin
      rnd_clamp = {1'b1, q[SUM_W-FRAC_W-1], {(FX_W-1){~q[SUM_W-FRAC_W-1]}}};
    end
  endfunction

endpackage
`default_nettype wire

@@ design/qau_mulrot.sv @@
`default_nettype none
module qau_mulrot (
  input  logic           clk,
  input  logic           en,
  input  logic [1:0]     act,
  input  qau_pkg::quat_t a,
  input  qau_pkg::quat_t b,
  output qau_pkg::res_t  res
);
  import qau_pkg::*;

  localparam int N1 [3] = '{1, 2, 0};
  localparam int N2 [3] = '{2, 0, 1};
  localparam sum_t SZERO = '0;

  prod_t         p_r [4][4];
  logic [1:0]    act1_r, act2_r, act3_r, act4_r, act5_r;
  quat_t         a1_r, a2_r, a3_r;
  sum_t          e [4][4];
  sum_t          s_nxt [4];
  sum_t          s_r [4];
  logic          mul;
  logic [FX_W:0] rc [4];
  quat_t         t_nxt;
  logic          tsat_nxt;
  quat_t         t_r;
  logic          tsat_r;
  prod_t         u_r [3][4];
  quat_t         m4_r, m5_r;
  logic          sat4_r, sat5_r;
  sum_t          v_nxt [3];
  sum_t          v_r [3];
  logic [FX_W:0] rv [3];
  res_t          res_nxt, res_r;

  always_comb begin
    mul = (act1_r == ACT_MUL);
    for (int i = 0; i < 4; i++) begin
      for (int j = 0; j < 4; j++) begin
        e[i][j] = sum_t'(p_r[i][j]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      s_nxt[i] = e[3][i] + e[N1[i]][N2[i]] - e[N2[i]][N1[i]] + (mul ? e[i][3] : SZERO);
    end
    s_nxt[3] = mul ? (e[3][3] - e[0][0] - e[1][1] - e[2][2]) : (e[0][0] + e[1][1] + e[2][2]);
  end

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      rc[i]    = rnd_clamp(s_r[i]);
      t_nxt[i] = $signed(rc[i][FX_W-1:0]);
    end
    tsat_nxt = rc[0][FX_W] | rc[1][FX_W] | rc[2][FX_W] | rc[3][FX_W];
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      v_nxt[i] = sum_t'(u_r[i][0]) + sum_t'(u_r[i][1]) - sum_t'(u_r[i][2])
               + sum_t'(u_r[i][3]);
      rv[i]    = rnd_clamp(v_r[i]);
    end
    if (act5_r == ACT_ROT) begin
      res_nxt.sat = sat5_r | rv[0][FX_W] | rv[1][FX_W] | rv[2][FX_W];
      res_nxt.x   = $signed(rv[0][FX_W-1:0]);
      res_nxt.y   = $signed(rv[1][FX_W-1:0]);
      res_nxt.z   = $signed(rv[2][FX_W-1:0]);
      res_nxt.w   = '0;
    end else begin
      res_nxt.sat = sat5_r;
      res_nxt.x   = m5_r[0];
      res_nxt.y   = m5_r[1];
      res_nxt.z   = m5_r[2];
      res_nxt.w   = m5_r[3];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 4; i++) begin
        for (int j = 0; j < 4; j++) begin
          p_r[i][j] <= a[i] * b[j];
        end
      end
      act1_r <= act;
      a1_r   <= a;
      s_r    <= s_nxt;
      act2_r <= act1_r;
      a2_r   <= a1_r;
      t_r    <= t_nxt;
      tsat_r <= tsat_nxt;
      act3_r <= act2_r;
      a3_r   <= a2_r;
      for (int i = 0; i < 3; i++) begin
        u_r[i][0] <= t_r[3] * a3_r[i];
        u_r[i][1] <= t_r[i] * a3_r[3];
        u_r[i][2] <= t_r[N1[i]] * a3_r[N2[i]];
        u_r[i][3] <= t_r[N2[i]] * a3_r[N1[i]];
      end
      m4_r   <= t_r;
      sat4_r <= tsat_r;
      act4_r <= act3_r;
      v_r    <= v_nxt;
      m5_r   <= m4_r;
      sat5_r <= sat4_r;
      act5_r <= act4_r;
      res_r  <= res_nxt;
    end
  end

  assign res = res_r;

endmodule
`default_nettype wire

@@ design/qau_sqrt.sv @@
`default_nettype none
module qau_sqrt (
  input  logic                         clk,
  input  logic                         en,
  input  logic [qau_pkg::RAD_W-1:0]    rad,
  output logic [qau_pkg::ROOT_W-1:0]   root
);
  import qau_pkg::*;

  localparam int unsigned REM_W = ROOT_W + 1;

  logic [REM_W-1:0]  rem_r   [ROOT_W];
  logic [RAD_W-1:0]  rad_r   [ROOT_W];
  logic [ROOT_W-1:0] root_r  [ROOT_W];
  logic [REM_W-1:0]  rem_in  [ROOT_W];
  logic [RAD_W-1:0]  rad_in  [ROOT_W];
  logic [ROOT_W-1:0] root_in [ROOT_W];
  logic [REM_W+1:0]  cur     [ROOT_W];
  logic [REM_W+1:0]  trial   [ROOT_W];

  always_comb begin
    rem_in[0]  = '0;
    rad_in[0]  = rad;
    root_in[0] = '0;
    for (int k = 1; k < ROOT_W; k++) begin
      rem_in[k]  = rem_r[k-1];
      rad_in[k]  = rad_r[k-1];
      root_in[k] = root_r[k-1];
    end
    for (int k = 0; k < ROOT_W; k++) begin
      cur[k]   = {rem_in[k], rad_in[k][RAD_W-1 -: 2]};
      trial[k] = {1'b0, root_in[k], 2'b01};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < ROOT_W; k++) begin
        if (cur[k] >= trial[k]) begin
          rem_r[k]  <= REM_W'(cur[k] - trial[k]);
          root_r[k] <= {root_in[k][ROOT_W-2:0], 1'b1};
        end else begin
          rem_r[k]  <= REM_W'(cur[k]);
          root_r[k] <= {root_in[k][ROOT_W-2:0], 1'b0};
        end
        rad_r[k] <= rad_in[k] << 2;
      end
    end
  end

  assign root = root_r[ROOT_W-1];

endmodule
`default_nettype wire

@@ design/qau_div.sv @@
`default_nettype none
module qau_div (
  input  logic                        clk,
  input  logic                        en,
  input  logic [qau_pkg::NUM_W-1:0]   num,
  input  logic [qau_pkg::ROOT_W-1:0]  den,
  output logic [qau_pkg::Q_W-1:0]     q
);
  import qau_pkg::*;

  localparam int unsigned REM_W = ROOT_W;

  logic [REM_W-1:0]  rem_r  [Q_W];
  logic [Q_W-1:0]    lo_r   [Q_W];
  logic [ROOT_W-1:0] den_r  [Q_W];
  logic [Q_W-1:0]    q_r    [Q_W];
  logic [REM_W-1:0]  rem_in [Q_W];
  logic [Q_W-1:0]    lo_in  [Q_W];
  logic [ROOT_W-1:0] den_in [Q_W];
  logic [Q_W-1:0]    q_in   [Q_W];
  logic [REM_W:0]    cur    [Q_W];
  logic              ge     [Q_W];

  always_comb begin
    rem_in[0] = REM_W'(num[NUM_W-1:Q_W]);
    lo_in[0]  = num[Q_W-1:0];
    den_in[0] = den;
    q_in[0]   = '0;
    for (int k = 1; k < Q_W; k++) begin
      rem_in[k] = rem_r[k-1];
      lo_in[k]  = lo_r[k-1];
      den_in[k] = den_r[k-1];
      q_in[k]   = q_r[k-1];
    end
    for (int k = 0; k < Q_W; k++) begin
      cur[k] = {rem_in[k], lo_in[k][Q_W-1]};
      ge[k]  = (cur[k] >= {1'b0, den_in[k]});
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < Q_W; k++) begin
        rem_r[k] <= ge[k] ? REM_W'(cur[k] - {1'b0, den_in[k]}) : REM_W'(cur[k]);
        q_r[k]   <= {q_in[k][Q_W-2:0], ge[k]};
        lo_r[k]  <= lo_in[k] << 1;
        den_r[k] <= den_in[k];
      end
    end
  end

  assign q = q_r[Q_W-1];

endmodule
`default_nettype wire

@@ design/qau_norm.sv @@
`default_nettype none
module qau_norm (
  input  logic           clk,
  input  logic           en,
  input  qau_pkg::quat_t a,
  output qau_pkg::quat_t r
);
  import qau_pkg::*;

  localparam int unsigned TOP_SH = M_W - 1;
  localparam int unsigned POS_W  = $clog2(FX_W);

  logic [FX_W-1:0]    mag [4];
  logic [FX_W-1:0]    mx01, mx23, mx_nxt;
  logic [FX_W-1:0]    m1_r [4];
  logic [FX_W-1:0]    mx1_r;
  logic [3:0]         neg1_r;
  logic [POS_W-1:0]   pos;
  logic [M_W-1:0]     ms_nxt [4];
  logic [M_W-1:0]     ms2_r [4];
  logic [3:0]         neg2_r;
  logic               zero2_r;
  logic [2*M_W-1:0]   sq3_r [4];
  logic [M_W-1:0]     ms3_r [4];
  logic [3:0]         neg3_r;
  logic               zero3_r;
  logic [RAD_W-1:0]   s4_r;
  logic [M_W-1:0]     ms4_r [4];
  logic [3:0]         neg4_r;
  logic               zero4_r;
  logic [M_W-1:0]     msd_r [ROOT_W][4];
  logic [3:0]         negd_r [ROOT_W];
  logic               zerod_r [ROOT_W];
  logic [ROOT_W-1:0]  root;
  logic [NUM_W-1:0]   num_r [4];
  logic [ROOT_W-1:0]  den_r;
  logic [3:0]         neg5_r;
  logic               zero5_r;
  logic [Q_W-1:0]     q [4];
  logic [3:0]         negq_r [Q_W];
  logic               zeroq_r [Q_W];
  quat_t              r_r;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      mag[i] = a[i][FX_W-1] ? (FX_W'(~a[i]) + 1'b1) : FX_W'(a[i]);
    end
    mx01   = (mag[0] > mag[1]) ? mag[0] : mag[1];
    mx23   = (mag[2] > mag[3]) ? mag[2] : mag[3];
    mx_nxt = (mx01 > mx23) ? mx01 : mx23;
  end

  always_comb begin
    pos = '0;
    for (int k = 0; k < FX_W; k++) begin
      if (mx1_r[k]) begin
        pos = POS_W'(k);
      end
    end
    for (int i = 0; i < 4; i++) begin
      if (pos >= TOP_SH) begin
        ms_nxt[i] = M_W'(m1_r[i] >> (pos - TOP_SH));
      end else begin
        ms_nxt[i] = M_W'(m1_r[i] << (TOP_SH - pos));
      end
    end
  end

  qau_sqrt u_sqrt (
    .clk  (clk),
    .en   (en),
    .rad  (s4_r),
    .root (root)
  );

  for (genvar g = 0; g < 4; g++) begin : g_lane
    qau_div u_div (
      .clk (clk),
      .en  (en),
      .num (num_r[g]),
      .den (den_r),
      .q   (q[g])
    );
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m1_r    <= mag;
      mx1_r   <= mx_nxt;
      neg1_r  <= {a[3][FX_W-1], a[2][FX_W-1], a[1][FX_W-1], a[0][FX_W-1]};
      ms2_r   <= ms_nxt;
      neg2_r  <= neg1_r;
      zero2_r <= (mx1_r == '0);
      for (int i = 0; i < 4; i++) begin
        sq3_r[i] <= ms2_r[i] * ms2_r[i];
      end
      ms3_r   <= ms2_r;
      neg3_r  <= neg2_r;
      zero3_r <= zero2_r;
      s4_r    <= RAD_W'(sq3_r[0]) + RAD_W'(sq3_r[1]) + RAD_W'(sq3_r[2]) + RAD_W'(sq3_r[3]);
      ms4_r   <= ms3_r;
      neg4_r  <= neg3_r;
      zero4_r <= zero3_r;
      msd_r[0]   <= ms4_r;
      negd_r[0]  <= neg4_r;
      zerod_r[0] <= zero4_r;
      for (int k = 1; k < ROOT_W; k++) begin
        msd_r[k]   <= msd_r[k-1];
        negd_r[k]  <= negd_r[k-1];
        zerod_r[k] <= zerod_r[k-1];
      end
      for (int i = 0; i < 4; i++) begin
        num_r[i] <= NUM_W'({msd_r[ROOT_W-1][i], {FRAC_W{1'b0}}}) + NUM_W'(root >> 1);
      end
      den_r   <= root;
      neg5_r  <= negd_r[ROOT_W-1];
      zero5_r <= zerod_r[ROOT_W-1];
      negq_r[0]  <= neg5_r;
      zeroq_r[0] <= zero5_r;
      for (int k = 1; k < Q_W; k++) begin
        negq_r[k]  <= negq_r[k-1];
        zeroq_r[k] <= zeroq_r[k-1];
      end
      for (int i = 0; i < 4; i++) begin
        if (zeroq_r[Q_W-1]) begin
          r_r[i] <= '0;
        end else if (negq_r[Q_W-1][i]) begin
          r_r[i] <= -$signed(FX_W'(q[i]));
        end else begin
          r_r[i] <= $signed(FX_W'(q[i]));
        end
      end
    end
  end

  assign r = r_r;

endmodule
`default_nettype wire

@@ design/quaternion_arith_unit_core.sv @@
// Latency: the same for every action, from an accepted input transaction to its result.
// Throughput: one transaction per cycle; the whole pipeline advances together and holds
// while a result waits on out_ready. The depth is set by the normalize path: a 30-stage
// square root and a 17-stage divider, one result bit per stage.
// Reset: synchronous, active low; clears all valid bits, no datapath state is reset.
`default_nettype none
module quaternion_arith_unit_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [1:0]                       in_action,
  input  logic signed [qau_pkg::FX_W-1:0]  in_a_x,
  input  logic signed [qau_pkg::FX_W-1:0]  in_a_y,
  input  logic signed [qau_pkg::FX_W-1:0]  in_a_z,
  input  logic signed [qau_pkg::FX_W-1:0]  in_a_w,
  input  logic signed [qau_pkg::FX_W-1:0]  in_b_x,
  input  logic signed [qau_pkg::FX_W-1:0]  in_b_y,
  input  logic signed [qau_pkg::FX_W-1:0]  in_b_z,
  input  logic signed [qau_pkg::FX_W-1:0]  in_b_w,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic signed [qau_pkg::FX_W-1:0]  out_r_x,
  output logic signed [qau_pkg::FX_W-1:0]  out_r_y,
  output logic signed [qau_pkg::FX_W-1:0]  out_r_z,
  output logic signed [qau_pkg::FX_W-1:0]  out_r_w,
  output logic                             out_saturated
);
  import qau_pkg::*;

  localparam int unsigned DLY = NORM_LAT - MR_LAT;

  logic              adv;
  logic [DEPTH-1:0]  vld_r;
  logic [1:0]        act_r [NORM_LAT];
  logic [1:0]        act_o;
  quat_t             in_a, in_b;
  res_t              mr;
  quat_t             nr;
  res_t              dly_r [DLY];
  res_t              out_nxt, out_r;

  assign adv      = ~vld_r[DEPTH-1] | out_ready;
  assign in_ready = adv;
  assign in_a     = '{in_a_x, in_a_y, in_a_z, in_a_w};
  assign in_b     = '{in_b_x, in_b_y, in_b_z, in_b_w};

  qau_mulrot u_mulrot (
    .clk (clk),
    .en  (adv),
    .act (in_action),
    .a   (in_a),
    .b   (in_b),
    .res (mr)
  );

  qau_norm u_norm (
    .clk (clk),
    .en  (adv),
    .a   (in_a),
    .r   (nr)
  );

  always_comb begin
    act_o = act_r[NORM_LAT-1];
    unique case (act_o)
      ACT_MUL, ACT_ROT: begin
        out_nxt = dly_r[DLY-1];
      end
      ACT_NORM: begin
        out_nxt.sat = 1'b0;
        out_nxt.x   = nr[0];
        out_nxt.y   = nr[1];
        out_nxt.z   = nr[2];
        out_nxt.w   = nr[3];
      end
      default: begin
        out_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[DEPTH-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      act_r[0] <= in_action;
      for (int k = 1; k < NORM_LAT; k++) begin
        act_r[k] <= act_r[k-1];
      end
      dly_r[0] <= mr;
      for (int k = 1; k < DLY; k++) begin
        dly_r[k] <= dly_r[k-1];
      end
      out_r <= out_nxt;
    end
  end

  assign out_valid     = vld_r[DEPTH-1];
  assign out_r_x       = out_r.x;
  assign out_r_y       = out_r.y;
  assign out_r_z       = out_r.z;
  assign out_r_w       = out_r.w;
  assign out_saturated = out_r.sat;

endmodule
`default_nettype wire

@@ design/qau_chk.sv @@
`default_nettype none
module qau_chk (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_ready,
  input logic [1:0]                       in_action,
  input logic signed [qau_pkg::FX_W-1:0]  in_a_x,
  input logic signed [qau_pkg::FX_W-1:0]  in_a_y,
  input logic signed [qau_pkg::FX_W-1:0]  in_a_z,
  input logic signed [qau_pkg::FX_W-1:0]  in_a_w,
  input logic signed [qau_pkg::FX_W-1:0]  in_b_x,
  input logic signed [qau_pkg::FX_W-1:0]  in_b_y,
  input logic signed [qau_pkg::FX_W-1:0]  in_b_z,
  input logic signed [qau_pkg::FX_W-1:0]  in_b_w,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic signed [qau_pkg::FX_W-1:0]  out_r_x,
  input logic signed [qau_pkg::FX_W-1:0]  out_r_y,
  input logic signed [qau_pkg::FX_W-1:0]  out_r_z,
  input logic signed [qau_pkg::FX_W-1:0]  out_r_w,
  input logic                             out_saturated
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_r_x) && $stable(out_r_y)
      && $stable(out_r_z) && $stable(out_r_w) && $stable(out_saturated))
    else $error("stalled result changed");

  // drop all results on reset
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // advance the pipeline unless a result is stalled
  a_ready_law: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output stall");

  // a new result appears only on a cycle the pipeline advanced
  a_rise_adv: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |=> !out_valid || $past(in_ready))
    else $error("result appeared without pipeline advance");

endmodule

bind quaternion_arith_unit_core qau_chk u_qau_chk (.*);
`default_nettype wire
